>>> rtl/ipp_pkg.sv
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared types and constants of the isometric point projection block.
// ----------------------------------------------------------------------------
package ipp_pkg;

    localparam int GRID_MAX_DEF = 1024;

    // pipeline depth, geometry and color paths run in lockstep
    localparam int NUM_STAGES = 5;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // cos(30 deg) as unsigned q0.16
    localparam logic [15:0] COS30_Q16 = 16'd56756;

    localparam logic [23:0] COLOR_FLAT  = 24'hFFFFFF;
    localparam logic [23:0] COLOR_BAND0 = 24'h3366FF;
    localparam logic [23:0] COLOR_BAND1 = 24'h33CCFF;
    localparam logic [23:0] COLOR_BAND2 = 24'h33FF66;
    localparam logic [23:0] COLOR_BAND3 = 24'hFFFF66;
    localparam logic [23:0] COLOR_BAND4 = 24'hFF3333;

    typedef enum logic [2:0] {
        REG_ZOOM         = 3'd0,
        REG_HEIGHT_SCALE = 3'd1,
        REG_OFFSET_X     = 3'd2,
        REG_OFFSET_Y     = 3'd3,
        REG_GRID_COLUMNS = 3'd4,
        REG_GRID_ROWS    = 3'd5,
        REG_HEIGHT_MIN   = 3'd6,
        REG_HEIGHT_MAX   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        [7:0]  zoom;
        logic signed [7:0]  height_scale;
        logic signed [12:0] offset_x;
        logic signed [12:0] offset_y;
        logic        [10:0] grid_columns;
        logic        [10:0] grid_rows;
        logic signed [15:0] height_min;
        logic signed [15:0] height_max;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctrl_t;

endpackage

>>> rtl/ipp_if.sv
// ----------------------------------------------------------------------------
// ipp_if
// Stream channels of the projection block: vertex in, screen point out.
// ----------------------------------------------------------------------------
interface ipp_vertex_if;
    logic               valid;
    logic               ready;
    logic        [9:0]  column;
    logic        [9:0]  row;
    logic signed [15:0] height;
    logic               has_color;
    logic        [23:0] given_color;

    modport source (output valid, column, row, height, has_color, given_color,
                    input ready);
    modport sink   (input valid, column, row, height, has_color, given_color,
                    output ready);
endinterface

interface ipp_point_if;
    logic               valid;
    logic               ready;
    logic signed [22:0] screen_x;
    logic signed [22:0] screen_y;
    logic        [23:0] color;

    modport source (output valid, screen_x, screen_y, color, input ready);
    modport sink   (input valid, screen_x, screen_y, color, output ready);
endinterface

>>> rtl/ipp_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipp_cfg_regs
// APB register file holding zoom, scale, offsets, grid size and height range.
// ----------------------------------------------------------------------------
module ipp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ipp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ipp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output ipp_pkg::cfg_t                    cfg
);

    ipp_pkg::cfg_t      cfg_reg;
    ipp_pkg::reg_index_t idx;
    logic               wr_en;

    assign idx    = ipp_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zoom         <= 8'd20;
            cfg_reg.height_scale <= 8'sd1;
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_y     <= '0;
            cfg_reg.grid_columns <= 11'd1;
            cfg_reg.grid_rows    <= 11'd1;
            cfg_reg.height_min   <= '0;
            cfg_reg.height_max   <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                ipp_pkg::REG_ZOOM:         cfg_reg.zoom         <= pwdata[7:0];
                ipp_pkg::REG_HEIGHT_SCALE: cfg_reg.height_scale <= pwdata[7:0];
                ipp_pkg::REG_OFFSET_X:     cfg_reg.offset_x     <= pwdata[12:0];
                ipp_pkg::REG_OFFSET_Y:     cfg_reg.offset_y     <= pwdata[12:0];
                ipp_pkg::REG_GRID_COLUMNS: cfg_reg.grid_columns <= pwdata[10:0];
                ipp_pkg::REG_GRID_ROWS:    cfg_reg.grid_rows    <= pwdata[10:0];
                ipp_pkg::REG_HEIGHT_MIN:   cfg_reg.height_min   <= pwdata[15:0];
                ipp_pkg::REG_HEIGHT_MAX:   cfg_reg.height_max   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ipp_pkg::REG_ZOOM:         prdata = {24'd0, cfg_reg.zoom};
            ipp_pkg::REG_HEIGHT_SCALE: prdata = {24'd0, cfg_reg.height_scale};
            ipp_pkg::REG_OFFSET_X:     prdata = {19'd0, cfg_reg.offset_x};
            ipp_pkg::REG_OFFSET_Y:     prdata = {19'd0, cfg_reg.offset_y};
            ipp_pkg::REG_GRID_COLUMNS: prdata = {21'd0, cfg_reg.grid_columns};
            ipp_pkg::REG_GRID_ROWS:    prdata = {21'd0, cfg_reg.grid_rows};
            ipp_pkg::REG_HEIGHT_MIN:   prdata = {16'd0, cfg_reg.height_min};
            ipp_pkg::REG_HEIGHT_MAX:   prdata = {16'd0, cfg_reg.height_max};
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> rtl/ipp_stage_ctrl.sv
// ----------------------------------------------------------------------------
// ipp_stage_ctrl
// Valid bits and per-stage load enables; bubbles collapse, stalls hold data.
// ----------------------------------------------------------------------------
module ipp_stage_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipp_pkg::stage_ctrl_t ctrl
);

    localparam int N = ipp_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   stage_ready;
    logic [N-1:0] prev_valid;

    assign prev_valid = {valid_reg[N-2:0], in_valid};

    always_comb
    begin
        stage_ready[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            // a stage can take a beat when empty or when its content moves on
            stage_ready[i] = ~valid_reg[i] | stage_ready[i+1];
        end
        for (int i = 0; i < N; i++)
        begin
            ctrl.load[i]  = stage_ready[i] & prev_valid[i];
            valid_next[i] = stage_ready[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[N-1];

endmodule

>>> rtl/ipp_geom.sv
// ----------------------------------------------------------------------------
// ipp_geom
// Coordinate path: centering, zoom and height products, cos30 scaling,
// truncating halving and offsets over five register stages.
// ----------------------------------------------------------------------------
module ipp_geom #(
    parameter int GRID_MAX = ipp_pkg::GRID_MAX_DEF
) (
    input  logic                 clk,
    input  ipp_pkg::cfg_t        cfg,
    input  ipp_pkg::stage_ctrl_t ctrl,
    input  logic        [9:0]    column,
    input  logic        [9:0]    row,
    input  logic signed [15:0]   height,
    output logic signed [22:0]   screen_x,
    output logic signed [22:0]   screen_y
);

    // grid sizes saturate here; an 11-bit register never exceeds 2047
    localparam int          GRID_CAP = (GRID_MAX > 2047) ? 2047 : GRID_MAX;
    localparam logic [10:0] GRID_LIM = 11'(GRID_CAP);

    logic [10:0] cols_sat;
    logic [10:0] rows_sat;
    logic [9:0]  half_c;
    logic [9:0]  half_r;

    assign cols_sat = (cfg.grid_columns > GRID_LIM) ? GRID_LIM : cfg.grid_columns;
    assign rows_sat = (cfg.grid_rows > GRID_LIM) ? GRID_LIM : cfg.grid_rows;
    assign half_c   = cols_sat[10:1];
    assign half_r   = rows_sat[10:1];

    // stage 0
    logic signed [11:0] dc_reg, dc_next;
    logic signed [11:0] dr_reg, dr_next;
    logic signed [23:0] z0_reg, z0_next;

    assign dc_next = $signed({2'b00, column}) - $signed({2'b00, half_c});
    assign dr_next = $signed({2'b00, row}) - $signed({2'b00, half_r});
    assign z0_next = 24'(height) * 24'(cfg.height_scale);

    // stage 1
    logic signed [19:0] px_reg, px_next;
    logic signed [19:0] py_reg, py_next;
    logic signed [23:0] z1_reg;

    assign px_next = 20'(dc_reg) * 20'($signed({1'b0, cfg.zoom}));
    assign py_next = 20'(dr_reg) * 20'($signed({1'b0, cfg.zoom}));

    // stage 2
    logic signed [20:0] dx_reg, dx_next;
    logic signed [25:0] sy2_reg, sy2_next;

    assign dx_next  = 21'(px_reg) - 21'(py_reg);
    assign sy2_next = 26'(px_reg) + 26'(py_reg) - 26'($signed({z1_reg, 1'b0}));

    // stage 3
    logic signed [37:0] prod_reg, prod_next;
    logic signed [24:0] hy_reg, hy_next;
    logic signed [25:0] sy_adj;

    assign prod_next = 38'(dx_reg) * 38'($signed({1'b0, ipp_pkg::COS30_Q16}));
    // halve toward zero: bias negatives by one before the shift
    assign sy_adj    = sy2_reg + $signed({25'd0, sy2_reg[25]});
    assign hy_next   = sy_adj[25:1];

    // stage 4
    logic signed [37:0] prod_adj;
    logic signed [22:0] sx_reg, sx_next;
    logic signed [24:0] sy_full;
    logic signed [22:0] sy_reg, sy_next;

    assign prod_adj = prod_reg + $signed({22'd0, {16{prod_reg[37]}}});
    assign sx_next  = 23'($signed(prod_adj[37:16])) + 23'(cfg.offset_x);
    assign sy_full  = hy_reg + 25'(cfg.offset_y);
    assign sy_next  = sy_full[22:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            dc_reg <= dc_next;
            dr_reg <= dr_next;
            z0_reg <= z0_next;
        end
        if (ctrl.load[1])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            z1_reg <= z0_reg;
        end
        if (ctrl.load[2])
        begin
            dx_reg  <= dx_next;
            sy2_reg <= sy2_next;
        end
        if (ctrl.load[3])
        begin
            prod_reg <= prod_next;
            hy_reg   <= hy_next;
        end
        if (ctrl.load[4])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign screen_x = sx_reg;
    assign screen_y = sy_reg;

endmodule

>>> rtl/ipp_color.sv
// ----------------------------------------------------------------------------
// ipp_color
// Color path: explicit color, flat color for a zero height range, or a
// height band by fifths of it, delayed to match the coordinate path.
// ----------------------------------------------------------------------------
module ipp_color (
    input  logic                 clk,
    input  ipp_pkg::cfg_t        cfg,
    input  ipp_pkg::stage_ctrl_t ctrl,
    input  logic signed [15:0]   height,
    input  logic                 has_color,
    input  logic        [23:0]   given_color,
    output logic        [23:0]   color
);

    // stage 0
    logic signed [16:0] d_reg, d_next;
    logic signed [16:0] r_reg, r_next;
    logic               has0_reg;
    logic        [23:0] given0_reg;

    assign d_next = 17'(height) - 17'(cfg.height_min);
    assign r_next = 17'(cfg.height_max) - 17'(cfg.height_min);

    // stage 1
    logic signed [19:0] d5_reg, d5_next;
    logic signed [19:0] r1_reg, r2_reg, r3_reg, r4_reg;
    logic signed [19:0] r2_next, r4_next;
    logic               has1_reg;
    logic        [23:0] given1_reg;

    assign d5_next = 20'($signed({d_reg, 2'b00})) + 20'(d_reg);
    assign r2_next = 20'($signed({r_reg, 1'b0}));
    assign r4_next = 20'($signed({r_reg, 2'b00}));

    // stage 2
    logic [23:0] c2_reg, c2_next;

    always_comb
    begin
        if (has1_reg)
            c2_next = given1_reg;
        else if (r1_reg == 20'sd0)
            c2_next = ipp_pkg::COLOR_FLAT;
        else if (r1_reg < 20'sd0)
            c2_next = ipp_pkg::COLOR_BAND0;
        else if (d5_reg < r1_reg)
            c2_next = ipp_pkg::COLOR_BAND0;
        else if (d5_reg < r2_reg)
            c2_next = ipp_pkg::COLOR_BAND1;
        else if (d5_reg < r3_reg)
            c2_next = ipp_pkg::COLOR_BAND2;
        else if (d5_reg < r4_reg)
            c2_next = ipp_pkg::COLOR_BAND3;
        else
            c2_next = ipp_pkg::COLOR_BAND4;
    end

    // stages 3 and 4 only delay
    logic [23:0] c3_reg;
    logic [23:0] c4_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            d_reg      <= d_next;
            r_reg      <= r_next;
            has0_reg   <= has_color;
            given0_reg <= given_color;
        end
        if (ctrl.load[1])
        begin
            d5_reg     <= d5_next;
            r1_reg     <= 20'(r_reg);
            r2_reg     <= r2_next;
            r3_reg     <= r2_next + 20'(r_reg);
            r4_reg     <= r4_next;
            has1_reg   <= has0_reg;
            given1_reg <= given0_reg;
        end
        if (ctrl.load[2])
            c2_reg <= c2_next;
        if (ctrl.load[3])
            c3_reg <= c2_reg;
        if (ctrl.load[4])
            c4_reg <= c3_reg;
    end

    assign color = c4_reg;

endmodule

>>> rtl/isometric_point_projection.sv
// ----------------------------------------------------------------------------
// isometric_point_projection
// Projects a grid vertex to isometric screen coordinates and picks its color.
// ----------------------------------------------------------------------------
// One vertex beat is accepted per clock unless the output stalls, and its
// point beat passes the five register stages of the coordinate path (centering
// and height product, zoom product, sum and difference, cos30 product and
// halving, rounding and offsets). Each stage holds its beat only while the
// stage after it cannot take a beat, so an output stall backs up one stage at
// a time and empty stages keep taking vertices. pready is always high. Users
// write registers over APB with the block idle, which it does not enforce.
module isometric_point_projection #(
    parameter int GRID_MAX = ipp_pkg::GRID_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ipp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ipp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ipp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    ipp_vertex_if.sink                     vertex,
    ipp_point_if.source                    point
);

    ipp_pkg::cfg_t        cfg;
    ipp_pkg::stage_ctrl_t ctrl;

    ipp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipp_stage_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_ready  (vertex.ready),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .ctrl      (ctrl)
    );

    ipp_geom #(
        .GRID_MAX (GRID_MAX)
    ) u_geom (
        .clk      (clk),
        .cfg      (cfg),
        .ctrl     (ctrl),
        .column   (vertex.column),
        .row      (vertex.row),
        .height   (vertex.height),
        .screen_x (point.screen_x),
        .screen_y (point.screen_y)
    );

    ipp_color u_color (
        .clk         (clk),
        .cfg         (cfg),
        .ctrl        (ctrl),
        .height      (vertex.height),
        .has_color   (vertex.has_color),
        .given_color (vertex.given_color),
        .color       (point.color)
    );

endmodule
